>>> sv/glyph_segment_reorder_defines.svh
// Assertion macros for the glyph segment reorder block.
`ifndef GLYPH_SEGMENT_REORDER_DEFINES_SVH
`define GLYPH_SEGMENT_REORDER_DEFINES_SVH
`ifndef SYNTHESIS
`define GSR_ASSERT_IMM(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph_segment_reorder: same-cycle check failed");
`define GSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph_segment_reorder: next-cycle check failed");
`else
`define GSR_ASSERT_IMM(lbl, ante, cons)
`define GSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/gsr_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package gsr_pkg;
	localparam int BUF_DEPTH = 256;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = IDX_W + 1;
	localparam int GLYPH_W   = 16;
	localparam int CHAR_W    = 16;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 3;

	localparam logic [GLYPH_W-1:0] GLYPH_DEL_A = 16'hFFFF;
	localparam logic [GLYPH_W-1:0] GLYPH_DEL_B = 16'hFFFE;

	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIXUP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_APPLY  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_ADJACENT = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_SKIPPED  = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_A_FETCH, S_A_FWAIT, S_B_CHK, S_B_WAIT, S_L_CHK, S_L_WAIT,
		S_CMP, S_H_RD, S_H_WR, S_S_RD, S_S_WR, S_D_RD, S_D_WR, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ACCEPT, OP_FETCH, OP_LOAD_FIX, OP_RD_BASE, OP_BASE_DEC,
		OP_RD_LIM, OP_LIM_INC, OP_CLR_I, OP_RD_GROUP, OP_WR_HOLD, OP_RD_SPAN,
		OP_WR_SPAN, OP_RD_HOLD, OP_WR_DEST, OP_NEXT
	} dp_op_t;

	typedef enum logic [1:0] {
		OUT_NONE, OUT_IMM, OUT_READ, OUT_APPLY
	} out_sel_t;

	typedef struct packed {
		dp_op_t   op;
		logic     skip;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic k_done;
		logic base_oob;
		logic base_zero;
		logic rd_del;
		logic lim_oob;
		logic lim_next_oob;
		logic lim_eq_base;
		logic lim_gt_base;
		logic i_eq_group;
		logic i_eq_span;
	} dp_stat_t;
endpackage

>>> sv/gsr_ctrl.sv
// Controller state machine sequencing requests and the fixup apply pass.
module gsr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gsr_pkg::MODE_W-1:0]   mode,
	input  gsr_pkg::dp_stat_t            stat,
	output gsr_pkg::cmd_t                cmd,
	output gsr_pkg::state_t              state
);
	import gsr_pkg::*;

	state_t state_q, state_d;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NONE;
		cmd.skip    = 1'b0;
		cmd.out_sel = OUT_NONE;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					cmd.op = OP_ACCEPT;
					if (mode == MODE_APPLY) begin
						state_d = S_A_FETCH;
					end else if (mode == MODE_READ) begin
						state_d = S_READ;
					end else begin
						cmd.out_sel = OUT_IMM;
					end
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.out_sel = OUT_READ;
					state_d     = S_IDLE;
				end
			end
			S_A_FETCH: begin
				if (stat.k_done) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_FETCH;
					state_d = S_A_FWAIT;
				end
			end
			S_A_FWAIT: begin
				cmd.op  = OP_LOAD_FIX;
				state_d = S_B_CHK;
			end
			S_B_CHK: begin
				if (stat.base_oob) begin
					cmd.op   = OP_NEXT;
					cmd.skip = 1'b1;
					state_d  = S_A_FETCH;
				end else begin
					cmd.op  = OP_RD_BASE;
					state_d = S_B_WAIT;
				end
			end
			S_B_WAIT: begin
				if (!stat.rd_del) begin
					state_d = S_L_CHK;
				end else if (stat.base_zero) begin
					cmd.op   = OP_NEXT;
					cmd.skip = 1'b1;
					state_d  = S_A_FETCH;
				end else begin
					cmd.op = OP_BASE_DEC;
				end
			end
			S_L_CHK: begin
				if (stat.lim_oob) begin
					cmd.op   = OP_NEXT;
					cmd.skip = 1'b1;
					state_d  = S_A_FETCH;
				end else begin
					cmd.op  = OP_RD_LIM;
					state_d = S_L_WAIT;
				end
			end
			S_L_WAIT: begin
				if (!stat.rd_del) begin
					state_d = S_CMP;
				end else if (stat.lim_next_oob) begin
					cmd.op   = OP_NEXT;
					cmd.skip = 1'b1;
					state_d  = S_A_FETCH;
				end else begin
					cmd.op = OP_LIM_INC;
				end
			end
			S_CMP: begin
				if (stat.lim_eq_base) begin
					cmd.op  = OP_NEXT;
					state_d = S_A_FETCH;
				end else if (stat.lim_gt_base) begin
					cmd.op   = OP_NEXT;
					cmd.skip = 1'b1;
					state_d  = S_A_FETCH;
				end else begin
					cmd.op  = OP_CLR_I;
					state_d = S_H_RD;
				end
			end
			S_H_RD: begin
				if (stat.i_eq_group) begin
					cmd.op  = OP_CLR_I;
					state_d = S_S_RD;
				end else begin
					cmd.op  = OP_RD_GROUP;
					state_d = S_H_WR;
				end
			end
			S_H_WR: begin
				cmd.op  = OP_WR_HOLD;
				state_d = S_H_RD;
			end
			S_S_RD: begin
				if (stat.i_eq_span) begin
					cmd.op  = OP_CLR_I;
					state_d = S_D_RD;
				end else begin
					cmd.op  = OP_RD_SPAN;
					state_d = S_S_WR;
				end
			end
			S_S_WR: begin
				cmd.op  = OP_WR_SPAN;
				state_d = S_S_RD;
			end
			S_D_RD: begin
				if (stat.i_eq_group) begin
					cmd.op  = OP_NEXT;
					state_d = S_A_FETCH;
				end else begin
					cmd.op  = OP_RD_HOLD;
					state_d = S_D_WR;
				end
			end
			S_D_WR: begin
				cmd.op  = OP_WR_DEST;
				state_d = S_D_RD;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_sel = OUT_APPLY;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

>>> sv/gsr_datapath.sv
// Datapath: glyph and fixup memories, walk pointers, counts and result register.
module gsr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gsr_pkg::cmd_t                 cmd,
	output gsr_pkg::dp_stat_t             stat,
	input  logic [gsr_pkg::MODE_W-1:0]    mode,
	input  logic [gsr_pkg::GLYPH_W-1:0]   glyph_id,
	input  logic [gsr_pkg::CHAR_W-1:0]    char_index,
	input  logic [gsr_pkg::IDX_W-1:0]     base_index,
	input  logic [gsr_pkg::IDX_W-1:0]     mpre_index,
	input  logic [gsr_pkg::IDX_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsr_pkg::GLYPH_W-1:0]   glyph_out,
	output logic [gsr_pkg::CHAR_W-1:0]    char_index_out,
	output logic [gsr_pkg::STAT_W-1:0]    status
);
	import gsr_pkg::*;

	localparam int ENT_W = GLYPH_W + CHAR_W;

	logic [ENT_W-1:0]     mem   [BUF_DEPTH];
	logic [ENT_W-1:0]     hold  [BUF_DEPTH];
	logic [2*IDX_W-1:0]   fixup [BUF_DEPTH];

	logic [CNT_W-1:0]     gcount_q, fcount_q, k_q;
	logic                 skip_q, out_valid_q, pos_ok_q;
	logic [IDX_W-1:0]     base_q, vowel_q;
	logic [CNT_W-1:0]     limit_q, i_q;
	logic [ENT_W-1:0]     rdata_q, hold_rdata_q;
	logic [2*IDX_W-1:0]   fix_rdata_q;
	logic [GLYPH_W-1:0]   glyph_out_q;
	logic [CHAR_W-1:0]    char_out_q;
	logic [STAT_W-1:0]    status_q;

	logic                 rd_en, wr_en;
	logic [IDX_W-1:0]     rd_addr, wr_addr;
	logic [ENT_W-1:0]     wr_data;
	logic [CNT_W-1:0]     group, span, lim_inc;
	logic [IDX_W-1:0]     dest;
	logic                 glyph_full, fixup_full, adjacent;
	logic [STAT_W-1:0]    imm_status;
	logic [GLYPH_W-1:0]   rd_glyph;

	assign group      = limit_q - {1'b0, vowel_q};
	assign span       = {1'b0, base_q} - limit_q;
	assign lim_inc    = limit_q + CNT_W'(1);
	assign dest       = base_q - group[IDX_W-1:0];
	assign glyph_full = (gcount_q == CNT_W'(BUF_DEPTH));
	assign fixup_full = (fcount_q == CNT_W'(BUF_DEPTH));
	// base - vowel <= 1 as signed, done in unsigned with one guard bit
	assign adjacent   = ({1'b0, base_index} <= ({1'b0, mpre_index} + CNT_W'(1)));
	assign rd_glyph   = rdata_q[ENT_W-1 -: GLYPH_W];

	always_comb begin
		case (mode)
			MODE_APPEND: imm_status = glyph_full ? ST_FULL : ST_OK;
			MODE_FIXUP:  imm_status = adjacent ? ST_ADJACENT : (fixup_full ? ST_FULL : ST_OK);
			default:     imm_status = ST_OK;
		endcase
	end

	// glyph memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = base_q;
		wr_en   = 1'b0;
		wr_addr = gcount_q[IDX_W-1:0];
		wr_data = {glyph_id, char_index};
		unique case (cmd.op)
			OP_ACCEPT: begin
				rd_en   = (mode == MODE_READ);
				rd_addr = position;
				wr_en   = (mode == MODE_APPEND) && !glyph_full;
			end
			OP_RD_BASE:  rd_en = 1'b1;
			OP_BASE_DEC: begin
				rd_en   = 1'b1;
				rd_addr = base_q - IDX_W'(1);
			end
			OP_RD_LIM: begin
				rd_en   = 1'b1;
				rd_addr = limit_q[IDX_W-1:0];
			end
			OP_LIM_INC: begin
				rd_en   = 1'b1;
				rd_addr = lim_inc[IDX_W-1:0];
			end
			OP_RD_GROUP: begin
				rd_en   = 1'b1;
				rd_addr = vowel_q + i_q[IDX_W-1:0];
			end
			OP_RD_SPAN: begin
				rd_en   = 1'b1;
				rd_addr = limit_q[IDX_W-1:0] + i_q[IDX_W-1:0];
			end
			OP_WR_SPAN: begin
				wr_en   = 1'b1;
				wr_addr = vowel_q + i_q[IDX_W-1:0];
				wr_data = rdata_q;
			end
			OP_WR_DEST: begin
				wr_en   = 1'b1;
				wr_addr = dest + i_q[IDX_W-1:0];
				wr_data = hold_rdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.op == OP_WR_HOLD) begin
			hold[i_q[IDX_W-1:0]] <= rdata_q;
		end
		if (cmd.op == OP_RD_HOLD) begin
			hold_rdata_q <= hold[i_q[IDX_W-1:0]];
		end
		if (cmd.op == OP_ACCEPT && mode == MODE_FIXUP && !adjacent && !fixup_full) begin
			fixup[fcount_q[IDX_W-1:0]] <= {base_index, mpre_index};
		end
		if (cmd.op == OP_FETCH) begin
			fix_rdata_q <= fixup[k_q[IDX_W-1:0]];
		end
	end

	// walk pointers and copy index
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: pos_ok_q <= ({1'b0, position} < gcount_q);
			OP_LOAD_FIX: begin
				base_q  <= fix_rdata_q[2*IDX_W-1 -: IDX_W];
				vowel_q <= fix_rdata_q[IDX_W-1:0];
				limit_q <= {1'b0, fix_rdata_q[IDX_W-1:0]} + CNT_W'(1);
			end
			OP_BASE_DEC: base_q <= base_q - IDX_W'(1);
			OP_LIM_INC:  limit_q <= lim_inc;
			OP_CLR_I:    i_q <= '0;
			OP_WR_HOLD, OP_WR_SPAN, OP_WR_DEST: i_q <= i_q + CNT_W'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcount_q    <= '0;
			fcount_q    <= '0;
			k_q         <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACCEPT) begin
				if (mode == MODE_APPEND && !glyph_full) begin
					gcount_q <= gcount_q + CNT_W'(1);
				end
				if (mode == MODE_FIXUP && !adjacent && !fixup_full) begin
					fcount_q <= fcount_q + CNT_W'(1);
				end
				if (mode == MODE_CLEAR) begin
					gcount_q <= '0;
					fcount_q <= '0;
				end
				k_q    <= '0;
				skip_q <= 1'b0;
			end
			if (cmd.op == OP_NEXT) begin
				k_q <= k_q + CNT_W'(1);
				if (cmd.skip) begin
					skip_q <= 1'b1;
				end
			end
			if (cmd.out_sel != OUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OUT_IMM: begin
				glyph_out_q <= '0;
				char_out_q  <= '0;
				status_q    <= imm_status;
			end
			OUT_READ: begin
				glyph_out_q <= pos_ok_q ? rd_glyph : '0;
				char_out_q  <= pos_ok_q ? rdata_q[CHAR_W-1:0] : '0;
				status_q    <= pos_ok_q ? ST_OK : ST_RANGE;
			end
			OUT_APPLY: begin
				glyph_out_q <= '0;
				char_out_q  <= '0;
				status_q    <= skip_q ? ST_SKIPPED : ST_OK;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign glyph_out      = glyph_out_q;
	assign char_index_out = char_out_q;
	assign status         = status_q;

	assign stat.out_free     = !out_valid_q || out_ready;
	assign stat.k_done       = (k_q >= fcount_q);
	assign stat.base_oob     = ({1'b0, base_q} >= gcount_q);
	assign stat.base_zero    = (base_q == '0);
	assign stat.rd_del       = (rd_glyph == GLYPH_DEL_A) || (rd_glyph == GLYPH_DEL_B);
	assign stat.lim_oob      = (limit_q >= gcount_q);
	assign stat.lim_next_oob = (lim_inc >= gcount_q);
	assign stat.lim_eq_base  = (limit_q == {1'b0, base_q});
	assign stat.lim_gt_base  = (limit_q > {1'b0, base_q});
	assign stat.i_eq_group   = (i_q == group);
	assign stat.i_eq_span    = (i_q == span);
endmodule

>>> sv/glyph_segment_reorder.sv
// Top level: pre-base vowel reordering over a 256-entry glyph buffer.
// Append, add fixup, clear: result registered in the cycle after the request is taken;
// read: memory read, then the result is registered once the result slot is free. Apply: per
// fixup a base walk and a vowel walk, plus hold, span and dest copies when the group moves;
// one request in flight. Reset: asynchronous, active low; clears both counts, the controller and out_valid.
module glyph_segment_reorder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsr_pkg::MODE_W-1:0]    mode,
	input  logic [gsr_pkg::GLYPH_W-1:0]   glyph_id,
	input  logic [gsr_pkg::CHAR_W-1:0]    char_index,
	input  logic [gsr_pkg::IDX_W-1:0]     base_index,
	input  logic [gsr_pkg::IDX_W-1:0]     mpre_index,
	input  logic [gsr_pkg::IDX_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsr_pkg::GLYPH_W-1:0]   glyph_out,
	output logic [gsr_pkg::CHAR_W-1:0]    char_index_out,
	output logic [gsr_pkg::STAT_W-1:0]    status
);
	import gsr_pkg::*;
	`include "glyph_segment_reorder_defines.svh"

	// Controller issues at most one datapath micro-op per cycle; datapath reports
	// compare results back. The result register lives in the datapath, so a
	// new request is taken while a finished result is being drained.
	cmd_t     cmd;
	dp_stat_t stat;
	state_t   ctrl_state;

	gsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd),
		.state    (ctrl_state)
	);

	gsr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.glyph_id       (glyph_id),
		.char_index     (char_index),
		.base_index     (base_index),
		.mpre_index     (mpre_index),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.glyph_out      (glyph_out),
		.char_index_out (char_index_out),
		.status         (status)
	);

	// requests only enter from idle and only when the result slot can take one
	`GSR_ASSERT_IMM(a_ready_idle, in_ready, (ctrl_state == S_IDLE) && (!out_valid || out_ready))
	// an apply request leaves the block busy, so in_ready drops once it is taken
	`GSR_ASSERT_NEXT(a_apply_busy, in_valid && in_ready && (mode == MODE_APPLY), !in_ready)
	// only a successful read carries data
	`GSR_ASSERT_IMM(a_err_zero, out_valid && (status != ST_OK), (glyph_out == '0) && (char_index_out == '0))
endmodule

>>> sim/tb.sv
// Testbench for glyph_segment_reorder: directed table then random reorder sequences.
module tb;
	import gsr_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	typedef struct {
		logic [GLYPH_W-1:0] glyph;
		logic [CHAR_W-1:0]  cidx;
		logic [STAT_W-1:0]  st;
	} reply_t;

	typedef struct {
		logic [MODE_W-1:0]  m;
		logic [GLYPH_W-1:0] g;
		logic [CHAR_W-1:0]  c;
		logic [IDX_W-1:0]   b;
		logic [IDX_W-1:0]   v;
		logic [IDX_W-1:0]   p;
		bit                 typed;
		logic [GLYPH_W-1:0] eg;
		logic [CHAR_W-1:0]  ec;
		logic [STAT_W-1:0]  es;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [MODE_W-1:0] mode;
	logic [GLYPH_W-1:0] glyph_id, glyph_out;
	logic [CHAR_W-1:0] char_index, char_index_out;
	logic [IDX_W-1:0] base_index, mpre_index, position;
	logic [STAT_W-1:0] status;

	// shadow copy of the block's buffer and fixup table
	logic [GLYPH_W-1:0] glyph_mem [BUF_DEPTH];
	logic [CHAR_W-1:0]  cidx_mem  [BUF_DEPTH];
	logic [IDX_W-1:0]   fix_base  [BUF_DEPTH];
	logic [IDX_W-1:0]   fix_vowel [BUF_DEPTH];
	int glyph_n, fix_n;

	reply_t pending_replies[$];
	int mismatches, sent, burst_left;

	glyph_segment_reorder uut (.*);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic bit is_deleted(logic [GLYPH_W-1:0] g);
		return g == GLYPH_DEL_A || g == GLYPH_DEL_B;
	endfunction

	// One fixup; returns 0 when a bound makes it skip.
	function automatic bit run_reorder(int b, int v);
		int lim, group, span, dest;
		logic [GLYPH_W-1:0] hg [BUF_DEPTH];
		logic [CHAR_W-1:0]  hc [BUF_DEPTH];
		lim = v + 1;
		if (b >= glyph_n) return 0;
		while (is_deleted(glyph_mem[b])) begin
			if (b == 0) return 0;
			b--;
		end
		if (lim >= glyph_n) return 0;
		while (is_deleted(glyph_mem[lim])) begin
			lim++;
			if (lim >= glyph_n) return 0;
		end
		if (lim == b) return 1;
		if (lim > b) return 0;
		group = lim - v;
		span = b - lim;
		dest = b - group;
		for (int i = 0; i < group; i++) begin
			hg[i] = glyph_mem[v + i];
			hc[i] = cidx_mem[v + i];
		end
		for (int i = 0; i < span; i++) begin
			glyph_mem[v + i] = glyph_mem[lim + i];
			cidx_mem[v + i] = cidx_mem[lim + i];
		end
		for (int i = 0; i < group; i++) begin
			glyph_mem[dest + i] = hg[i];
			cidx_mem[dest + i] = hc[i];
		end
		return 1;
	endfunction

	function automatic reply_t reorder_step(logic [MODE_W-1:0] m, logic [GLYPH_W-1:0] g,
			logic [CHAR_W-1:0] c, logic [IDX_W-1:0] b, logic [IDX_W-1:0] v,
			logic [IDX_W-1:0] p);
		reply_t r;
		r = '{0, 0, ST_OK};
		case (m)
			MODE_APPEND: begin
				if (glyph_n >= BUF_DEPTH) r.st = ST_FULL;
				else begin
					glyph_mem[glyph_n] = g;
					cidx_mem[glyph_n] = c;
					glyph_n++;
				end
			end
			MODE_FIXUP: begin
				if (int'(b) - int'(v) <= 1) r.st = ST_ADJACENT;
				else if (fix_n >= BUF_DEPTH) r.st = ST_FULL;
				else begin
					fix_base[fix_n] = b;
					fix_vowel[fix_n] = v;
					fix_n++;
				end
			end
			MODE_APPLY: begin
				for (int k = 0; k < fix_n; k++)
					if (!run_reorder(fix_base[k], fix_vowel[k])) r.st = ST_SKIPPED;
			end
			MODE_READ: begin
				if (p < glyph_n) begin
					r.glyph = glyph_mem[p];
					r.cidx = cidx_mem[p];
				end else r.st = ST_RANGE;
			end
			MODE_CLEAR: begin
				glyph_n = 0;
				fix_n = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_request(row_t row);
		reply_t r;
		in_valid = 1'b1;
		mode = row.m;
		glyph_id = row.g;
		char_index = row.c;
		base_index = row.b;
		mpre_index = row.v;
		position = row.p;
		do @(posedge clk); while (!in_ready);
		r = reorder_step(row.m, row.g, row.c, row.b, row.v, row.p);
		if (row.typed) r = '{row.eg, row.ec, row.es};
		pending_replies.push_back(r);
		sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end else burst_left--;
	endtask

	task automatic send_op(logic [MODE_W-1:0] m, logic [GLYPH_W-1:0] g, logic [CHAR_W-1:0] c,
			logic [IDX_W-1:0] b, logic [IDX_W-1:0] v, logic [IDX_W-1:0] p);
		send_request('{m, g, c, b, v, p, 1'b0, 0, 0, 0});
	endtask

	// Receiver: stall pattern picked at random from three phases; one long hold-off to back up
	// the input side. Results are checked at the rising edge.
	initial begin
		int phase, tick, hold;
		reply_t want;
		bit long_done;
		out_ready = 1'b0;
		phase = 0; tick = 0; hold = 0; long_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("result with none expected: %h %h %0d",
						glyph_out, char_index_out, status);
				end else begin
					want = pending_replies.pop_front();
					if (glyph_out !== want.glyph || char_index_out !== want.cidx ||
							status !== want.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h %h %0d got %h %h %0d",
								want.glyph, want.cidx, want.st,
								glyph_out, char_index_out, status);
					end
				end
			end
			@(negedge clk);
			if (!long_done && sent >= 300) begin
				long_done = 1;
				hold = 500;
			end
			if (tick % 64 == 0) phase = $urandom_range(0, 2);
			tick++;
			if (hold > 0) begin
				hold--;
				out_ready = 1'b0;
			end else case (phase)
				0: out_ready = 1'b1;
				1: out_ready = $urandom_range(0, 1);
				default: out_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#300_000_000;
		$display("TB_ERROR");
		$finish;
	end

	row_t directed [] = '{
		'{MODE_READ,   0, 0, 0, 0, 0,          1, 0, 0, ST_RANGE},
		'{MODE_APPLY,  0, 0, 0, 0, 0,          1, 0, 0, ST_OK},
		'{MODE_APPEND, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_APPEND, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_APPEND, 16'hFFFE, 16'h5555, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_APPEND, 16'h1234, 16'hAAAA, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_APPEND, 16'hABCD, 16'h0001, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_APPEND, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0, 0},
		'{MODE_READ,   0, 0, 0, 0, 0,          1, 16'h0000, 16'hFFFF, ST_OK},
		'{MODE_READ,   0, 0, 0, 0, 255,        1, 0, 0, ST_RANGE},
		'{MODE_FIXUP,  0, 0, 1, 0, 0,          1, 0, 0, ST_ADJACENT},
		'{MODE_FIXUP,  0, 0, 0, 255, 0,        1, 0, 0, ST_ADJACENT},
		'{MODE_FIXUP,  0, 0, 5, 5, 0,          1, 0, 0, ST_ADJACENT},
		'{MODE_FIXUP,  0, 0, 3, 0, 0,          1, 0, 0, ST_OK},
		'{MODE_FIXUP,  0, 0, 255, 0, 0,        1, 0, 0, ST_OK},
		'{MODE_APPLY,  0, 0, 0, 0, 0,          1, 0, 0, ST_SKIPPED},
		'{MODE_READ,   0, 0, 0, 0, 0,          0, 0, 0, 0},
		'{MODE_READ,   0, 0, 0, 0, 3,          0, 0, 0, 0},
		'{MODE_APPLY,  0, 0, 0, 0, 0,          1, 0, 0, ST_SKIPPED},
		'{MODE_READ,   0, 0, 0, 0, 2,          0, 0, 0, 0},
		'{MODE_SPARE_LO, 16'hFFFF, 16'hFFFF, 255, 255, 255, 1, 0, 0, ST_OK},
		'{MODE_SPARE_HI, 16'hFFFF, 16'hFFFF, 255, 255, 255, 1, 0, 0, ST_OK},
		'{MODE_CLEAR,  0, 0, 0, 0, 0,          1, 0, 0, ST_OK},
		'{MODE_READ,   0, 0, 0, 0, 0,          1, 0, 0, ST_RANGE}
	};

	initial begin
		int n, nf, v, b, waited;
		in_valid = 1'b0;
		mode = '0; glyph_id = '0; char_index = '0;
		base_index = '0; mpre_index = '0; position = '0;
		glyph_n = 0; fix_n = 0; mismatches = 0; sent = 0; burst_left = 5;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_request(directed[i]);

		while (sent < 1000) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: anything the fields allow, reads and applies gated by counts
				send_op(MODE_W'($urandom_range(0, 7)), GLYPH_W'($urandom), CHAR_W'($urandom),
					IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
			end else begin
				send_op(MODE_CLEAR, 0, 0, 0, 0, 0);
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 258)
					: $urandom_range(3, 20);
				for (int i = 0; i < n; i++)
					send_op(MODE_APPEND, ($urandom_range(0, 3) == 0) ?
						($urandom_range(0, 1) ? GLYPH_DEL_A : GLYPH_DEL_B) :
						GLYPH_W'($urandom), CHAR_W'($urandom), 0, 0, 0);
				if (n <= 20 && $urandom_range(0, 39) == 0) nf = 258;
				else nf = $urandom_range(1, 6);
				for (int i = 0; i < nf; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						send_op(MODE_FIXUP, 0, 0, IDX_W'($urandom), IDX_W'($urandom), 0);
					end else begin
						v = $urandom_range(0, (n > 256 ? 256 : n) - 1);
						b = v + $urandom_range(1, 10);
						if (b > 255) b = 255;
						send_op(MODE_FIXUP, 0, 0, IDX_W'(b), IDX_W'(v), 0);
					end
				end
				send_op(MODE_APPLY, 0, 0, 0, 0, 0);
				if ($urandom_range(0, 3) == 0) send_op(MODE_APPLY, 0, 0, 0, 0, 0);
				for (int i = 0; i < (n > 24 ? 24 : n + 1); i++)
					send_op(MODE_READ, 0, 0, 0, 0, IDX_W'((i < n) ? i : $urandom));
			end
		end
		in_valid = 1'b0;

		waited = 0;
		while (pending_replies.size() != 0 && waited < 2_000_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+sv
sv/gsr_pkg.sv
sv/gsr_ctrl.sv
sv/gsr_datapath.sv
sv/glyph_segment_reorder.sv
sim/tb.sv
